/* hw/rtl/qtg_pkg.sv */
// ============================================================================
// qtg_pkg - shared types and constants of the quartic trajectory generator
// Fixed formats, command and status bundles between controller and datapath.
// ============================================================================
package qtg_pkg;

    // Value and coefficient formats
    localparam int VALUE_W    = 32;
    localparam int COEF_W     = 48;
    localparam int FRAC_BITS  = 24;
    localparam int TAU_BITS   = 32;
    localparam int ACC_W      = 64;

    // Shared multiplier: 64-bit magnitude split in two 32-bit halves
    localparam int MUL_A_W    = 64;
    localparam int MUL_HALF_W = 32;
    localparam int MUL_PROD_W = 64;
    localparam int PROD_W     = MUL_A_W + MUL_HALF_W;

    // Shared divider
    localparam int DIV_Q_W       = 34;
    localparam int DIV_ITERS_TAU = 32;
    localparam int DIV_ITERS_VEL = 34;
    localparam int DIV_PRE_SHIFT = DIV_ITERS_VEL - FRAC_BITS;
    localparam int CNT_W         = 6;

    // Stream widths
    localparam int IN_DATA_W  = 4 * VALUE_W;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = ((2 * VALUE_W + 1 + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_RESET    = 2'd0,
        OP_SET_POS  = 2'd1,
        OP_SET_DEST = 2'd2,
        OP_TICK     = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        SP_NONE,
        SP_ACCEPT,
        SP_CLEAR,
        SP_SET_POS,
        SP_DEST_INIT,
        SP_TICK_INIT,
        SP_MUL_LOAD,
        SP_MUL_LO,
        SP_MUL_HI,
        SP_MUL_SUM,
        SP_MUL_WB,
        SP_COEF,
        SP_DIV_LOAD,
        SP_DIV_RUN,
        SP_DIV_WB,
        SP_LOAD_OUT
    } step_t;

    // Products in the order the controller walks them
    typedef enum logic [3:0] {
        PR_SV_T,
        PR_VV_T,
        PR_TAU2,
        PR_TAU3,
        PR_TAU4,
        PR_SV_E,
        PR_A_TAU2,
        PR_J_TAU3,
        PR_Q_TAU4,
        PR_2A_TAU,
        PR_3J_TAU2,
        PR_4Q_TAU3
    } prod_t;

    typedef enum logic {
        DV_TAU,
        DV_VEL
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL_LOAD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_SUM,
        ST_MUL_WB,
        ST_COEF,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_WB,
        ST_OUT
    } state_t;

    typedef struct packed {
        step_t    step;
        prod_t    prod;
        div_sel_t div_sel;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic travel_zero;
        logic reached;
    } status_t;

endpackage

/* hw/rtl/quartic_trajectory_generator_unit.sv */
// ============================================================================
// quartic_trajectory_generator_unit - quartic motion profile generator
// Reset, set-position, set-destination and tick commands in; current
// position, velocity and arrival flag out, one result per command.
// ============================================================================
// Usage:
//   s_ channel carries one command per transfer, s_tuser selects the command.
//   m_ channel returns one result per command: state after the command.
//   One command is worked on at a time; s_tready is high only while idle.
//   Work done per command:
//     reset, set position, tick at or past arrival: no products or divisions
//     set destination: two products on the shared multiplier (none if zero travel)
//     tick while moving: a 32-step and a 34-step restoring division,
//       one quotient bit a cycle, and ten products on the shared multiplier
//   The next command is taken the cycle after the result is registered.
//   The result sits in an output register: while the receiver stalls the
//   next command is still accepted and worked on, and the controller holds
//   in its output state only when a second result is ready before the
//   first has been taken.
//   Reset clears the motion state (all zero, arrived reads 1) and empties
//   the output register.
// ============================================================================
module quartic_trajectory_generator_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tdata: target_position[31:0], target_velocity[63:32],
    //        travel_time[95:64], time_step[127:96]
    input  logic [qtg_pkg::IN_DATA_W-1:0]       s_tdata,
    // tuser: op[1:0]
    input  logic [qtg_pkg::IN_USER_W-1:0]       s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: position[31:0], velocity[63:32], arrived[64], zero pad[71:65]
    output logic [qtg_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready
);
    import qtg_pkg::*;

    cmd_t    cmd;
    status_t status;

    qtg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    qtg_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata)
    );

`ifndef SYNTH
    // Never overwrite a result the receiver has not taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step == SP_LOAD_OUT |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while stalled");

    // One command in flight: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second command accepted while busy");

    // A new result appears only from a register load
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.step == SP_LOAD_OUT))
        else $error("result valid without a load");
`endif

endmodule

/* hw/rtl/qtg_ctrl.sv */
// ============================================================================
// qtg_ctrl - sequencer of the quartic trajectory generator
// Walks each command through products and divisions on the shared units and
// owns the stream handshakes.
// ============================================================================
module qtg_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  qtg_pkg::status_t status,
    output qtg_pkg::cmd_t    cmd
);
    import qtg_pkg::*;

    state_t           state_reg, state_next;
    prod_t            prod_reg, prod_next;
    div_sel_t         div_sel_reg, div_sel_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_tready;

    // Next state
    always_comb begin
        state_next   = state_reg;
        prod_next    = prod_reg;
        div_sel_next = div_sel_reg;
        cnt_next     = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (status.op)
                    OP_SET_DEST: begin
                        if (status.travel_zero) begin
                            state_next = ST_OUT;
                        end else begin
                            prod_next  = PR_SV_T;
                            state_next = ST_MUL_LOAD;
                        end
                    end
                    OP_TICK: begin
                        if (status.reached) begin
                            state_next = ST_OUT;
                        end else begin
                            div_sel_next = DV_TAU;
                            state_next   = ST_DIV_LOAD;
                        end
                    end
                    default: state_next = ST_OUT;
                endcase
            end
            ST_MUL_LOAD: state_next = ST_MUL_LO;
            ST_MUL_LO:   state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_MUL_SUM;
            ST_MUL_SUM:  state_next = ST_MUL_WB;
            ST_MUL_WB: begin
                if (prod_reg == PR_VV_T) begin
                    state_next = ST_COEF;
                end else if (prod_reg == PR_4Q_TAU3) begin
                    div_sel_next = DV_VEL;
                    state_next   = ST_DIV_LOAD;
                end else begin
                    prod_next  = prod_t'(prod_reg + 4'd1);
                    state_next = ST_MUL_LOAD;
                end
            end
            ST_COEF: state_next = ST_OUT;
            ST_DIV_LOAD: begin
                cnt_next   = (div_sel_reg == DV_TAU) ? CNT_W'(DIV_ITERS_TAU - 1)
                                                     : CNT_W'(DIV_ITERS_VEL - 1);
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                if (cnt_reg == '0) begin
                    state_next = ST_DIV_WB;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DIV_WB: begin
                if (div_sel_reg == DV_TAU) begin
                    prod_next  = PR_TAU2;
                    state_next = ST_MUL_LOAD;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        cmd.step    = SP_NONE;
        cmd.prod    = prod_reg;
        cmd.div_sel = div_sel_reg;
        case (state_reg)
            ST_IDLE:     cmd.step = s_tvalid ? SP_ACCEPT : SP_NONE;
            ST_DECODE: begin
                case (status.op)
                    OP_RESET:    cmd.step = SP_CLEAR;
                    OP_SET_POS:  cmd.step = SP_SET_POS;
                    OP_SET_DEST: cmd.step = SP_DEST_INIT;
                    default:     cmd.step = SP_TICK_INIT;
                endcase
            end
            ST_MUL_LOAD: cmd.step = SP_MUL_LOAD;
            ST_MUL_LO:   cmd.step = SP_MUL_LO;
            ST_MUL_HI:   cmd.step = SP_MUL_HI;
            ST_MUL_SUM:  cmd.step = SP_MUL_SUM;
            ST_MUL_WB:   cmd.step = SP_MUL_WB;
            ST_COEF:     cmd.step = SP_COEF;
            ST_DIV_LOAD: cmd.step = SP_DIV_LOAD;
            ST_DIV_RUN:  cmd.step = SP_DIV_RUN;
            ST_DIV_WB:   cmd.step = SP_DIV_WB;
            ST_OUT:      cmd.step = out_free ? SP_LOAD_OUT : SP_NONE;
            default:     cmd.step = SP_NONE;
        endcase
    end

    // Hold the result valid until the receiver takes the transfer
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            prod_reg    <= PR_SV_T;
            div_sel_reg <= DV_TAU;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            prod_reg    <= prod_next;
            div_sel_reg <= div_sel_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

/* hw/rtl/qtg_datapath.sv */
// ============================================================================
// qtg_datapath - state, shared multiplier and shared divider
// Executes one step per cycle as commanded; holds the motion state and the
// output register.
// ============================================================================
module qtg_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  qtg_pkg::cmd_t                     cmd,
    output qtg_pkg::status_t                  status,
    input  logic [qtg_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [qtg_pkg::IN_USER_W-1:0]     s_tuser,
    output logic [qtg_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import qtg_pkg::*;

    // Motion state
    logic signed [VALUE_W-1:0] sp_reg, sp_next, sv_reg, sv_next;
    logic signed [VALUE_W-1:0] gp_reg, gp_next, gv_reg, gv_next;
    logic signed [VALUE_W-1:0] cp_reg, cp_next, cv_reg, cv_next;
    logic        [VALUE_W-1:0] arr_reg, arr_next, el_reg, el_next;
    logic signed [COEF_W-1:0]  ac_reg, ac_next, jc_reg, jc_next, qc_reg, qc_next;

    // Latched command
    op_t                       op_reg, op_next;
    logic signed [VALUE_W-1:0] tpos_reg, tpos_next, tvel_reg, tvel_next;
    logic        [VALUE_W-1:0] ttime_reg, ttime_next, tstep_reg, tstep_next;

    // Working registers
    logic signed [ACC_W-1:0]    p_reg, p_next, vt_reg, vt_next;
    logic signed [ACC_W-1:0]    pos_acc_reg, pos_acc_next, d_acc_reg, d_acc_next;
    logic [TAU_BITS-1:0]        tau_reg, tau_next, tau2_reg, tau2_next;
    logic [TAU_BITS-1:0]        tau3_reg, tau3_next, tau4_reg, tau4_next;
    logic [MUL_A_W-1:0]         mul_a_reg, mul_a_next;
    logic [MUL_HALF_W-1:0]      mul_b_reg, mul_b_next;
    logic                       mul_neg_reg, mul_neg_next, mul_sh32_reg, mul_sh32_next;
    logic [MUL_PROD_W-1:0]      plo_reg, plo_next, phi_reg, phi_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic [VALUE_W-1:0]         rem_reg, rem_next;
    logic [DIV_Q_W-1:0]         q_reg, q_next, lo_reg, lo_next;
    logic                       div_ovf_reg, div_ovf_next, div_neg_reg, div_neg_next;

    // Output register
    logic signed [VALUE_W-1:0]  out_pos_reg, out_pos_next, out_vel_reg, out_vel_next;
    logic                       out_arr_reg, out_arr_next;

    // Combinational helpers
    logic [VALUE_W:0]           e_sum;
    logic [VALUE_W-1:0]         e_sat;
    logic                       reached;
    logic [ACC_W-1:0]           mul_mag;
    logic signed [ACC_W-1:0]    mul_res;
    logic signed [ACC_W-1:0]    sv_w, gp_w, sp_w, vv_w, ac_w, jc_w, qc_w;
    logic [ACC_W-1:0]           jc_mag;
    logic signed [ACC_W-1:0]    p3, q_raw, j_raw, a_raw;
    logic [ACC_W-1:0]           dmag, dhi;
    logic [VALUE_W:0]           trial, trial_diff;
    logic [DIV_Q_W-1:0]         qmag;
    logic signed [ACC_W-1:0]    dv_w, vsum;
    logic signed [VALUE_W-1:0]  pos_clamped;

    function automatic logic [ACC_W-1:0] abs_acc(input logic signed [ACC_W-1:0] x);
        logic [ACC_W-1:0] ux;
        ux = x;
        return x[ACC_W-1] ? (~ux + 1'b1) : ux;
    endfunction

    function automatic logic signed [COEF_W-1:0] sat_coef(
        input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi, lo;
        hi = {{(ACC_W-COEF_W+1){1'b0}}, {(COEF_W-1){1'b1}}};
        lo = ~hi;
        if (x > hi) begin
            return hi[COEF_W-1:0];
        end else if (x < lo) begin
            return lo[COEF_W-1:0];
        end
        return x[COEF_W-1:0];
    endfunction

    function automatic logic signed [VALUE_W-1:0] sat_value(
        input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi, lo;
        hi = {{(ACC_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
        lo = ~hi;
        if (x > hi) begin
            return hi[VALUE_W-1:0];
        end else if (x < lo) begin
            return lo[VALUE_W-1:0];
        end
        return x[VALUE_W-1:0];
    endfunction

    // Elapsed time after a tick, saturating at the largest time
    assign e_sum   = {1'b0, el_reg} + {1'b0, tstep_reg};
    assign e_sat   = e_sum[VALUE_W] ? '1 : e_sum[VALUE_W-1:0];
    assign reached = (e_sat >= arr_reg);

    assign status.op          = op_reg;
    assign status.travel_zero = (ttime_reg == '0);
    assign status.reached     = reached;

    // Truncate the product toward zero and restore its sign
    assign mul_mag = mul_sh32_reg ? prod_reg[TAU_BITS +: ACC_W]
                                  : prod_reg[FRAC_BITS +: ACC_W];
    assign mul_res = mul_neg_reg ? -$signed(mul_mag) : $signed(mul_mag);

    assign sv_w   = ACC_W'(sv_reg);
    assign sp_w   = ACC_W'(sp_reg);
    assign gp_w   = ACC_W'(gp_reg);
    assign vv_w   = ACC_W'(gv_reg) - sv_w;
    assign ac_w   = ACC_W'(ac_reg);
    assign jc_w   = ACC_W'(jc_reg);
    assign qc_w   = ACC_W'(qc_reg);
    assign jc_mag = abs_acc(jc_w);

    // Coefficients of the quartic from P and V*T
    assign p3    = (p_reg <<< 1) + p_reg;
    assign q_raw = p3 - (vt_reg <<< 1);
    assign j_raw = (vt_reg <<< 2) + vt_reg - (p_reg <<< 3);
    assign a_raw = (p3 <<< 1) - (vt_reg <<< 1) - vt_reg;

    // Divider operands and one restoring step
    assign dmag       = abs_acc(d_acc_reg);
    assign dhi        = dmag >> DIV_PRE_SHIFT;
    assign trial      = {rem_reg, lo_reg[DIV_Q_W-1]};
    assign trial_diff = trial - {1'b0, arr_reg};

    // Velocity from the quotient, position clamped to 0..1
    assign qmag = div_ovf_reg ? '1 : q_reg;
    assign dv_w = div_neg_reg ? -$signed(ACC_W'(qmag)) : $signed(ACC_W'(qmag));
    assign vsum = sv_w + dv_w;

    always_comb begin
        if (pos_acc_reg < 0) begin
            pos_clamped = '0;
        end else if (pos_acc_reg > ACC_W'(1 << FRAC_BITS)) begin
            pos_clamped = VALUE_W'(1 << FRAC_BITS);
        end else begin
            pos_clamped = pos_acc_reg[VALUE_W-1:0];
        end
    end

    // Step execution
    always_comb begin
        sp_next = sp_reg;  sv_next = sv_reg;  gp_next = gp_reg;  gv_next = gv_reg;
        cp_next = cp_reg;  cv_next = cv_reg;  arr_next = arr_reg; el_next = el_reg;
        ac_next = ac_reg;  jc_next = jc_reg;  qc_next = qc_reg;
        op_next = op_reg;  tpos_next = tpos_reg; tvel_next = tvel_reg;
        ttime_next = ttime_reg; tstep_next = tstep_reg;
        p_next = p_reg;  vt_next = vt_reg;  pos_acc_next = pos_acc_reg;
        d_acc_next = d_acc_reg;
        tau_next = tau_reg;  tau2_next = tau2_reg;  tau3_next = tau3_reg;
        tau4_next = tau4_reg;
        mul_a_next = mul_a_reg;  mul_b_next = mul_b_reg;
        mul_neg_next = mul_neg_reg;  mul_sh32_next = mul_sh32_reg;
        plo_next = plo_reg;  phi_next = phi_reg;  prod_next = prod_reg;
        rem_next = rem_reg;  q_next = q_reg;  lo_next = lo_reg;
        div_ovf_next = div_ovf_reg;  div_neg_next = div_neg_reg;
        out_pos_next = out_pos_reg;  out_vel_next = out_vel_reg;
        out_arr_next = out_arr_reg;

        case (cmd.step)
            SP_ACCEPT: begin
                op_next    = op_t'(s_tuser);
                tpos_next  = s_tdata[0 +: VALUE_W];
                tvel_next  = s_tdata[VALUE_W +: VALUE_W];
                ttime_next = s_tdata[2*VALUE_W +: VALUE_W];
                tstep_next = s_tdata[3*VALUE_W +: VALUE_W];
            end
            SP_CLEAR, SP_SET_POS: begin
                sp_next = '0;  sv_next = '0;  gp_next = '0;  gv_next = '0;
                cp_next = '0;  cv_next = '0;  arr_next = '0; el_next = '0;
                ac_next = '0;  jc_next = '0;  qc_next = '0;
                if (cmd.step == SP_SET_POS) begin
                    sp_next = tpos_reg;
                    gp_next = tpos_reg;
                    cp_next = tpos_reg;
                    gv_next = tvel_reg;
                    cv_next = tvel_reg;
                end
            end
            SP_DEST_INIT: begin
                sp_next  = cp_reg;
                sv_next  = cv_reg;
                gp_next  = tpos_reg;
                gv_next  = tvel_reg;
                arr_next = ttime_reg;
                el_next  = '0;
                ac_next  = '0;
                jc_next  = '0;
                qc_next  = '0;
            end
            SP_TICK_INIT: begin
                // Snap to the goal on arrival
                if (reached) begin
                    cp_next = gp_reg;
                    cv_next = gv_reg;
                    el_next = arr_reg;
                end else begin
                    el_next = e_sat;
                end
            end
            SP_MUL_LOAD: begin
                mul_neg_next  = 1'b0;
                mul_sh32_next = 1'b1;
                mul_a_next    = '0;
                mul_b_next    = tau_reg;
                case (cmd.prod)
                    PR_SV_T: begin
                        mul_a_next    = abs_acc(sv_w);
                        mul_b_next    = arr_reg;
                        mul_neg_next  = sv_w[ACC_W-1];
                        mul_sh32_next = 1'b0;
                    end
                    PR_VV_T: begin
                        mul_a_next    = abs_acc(vv_w);
                        mul_b_next    = arr_reg;
                        mul_neg_next  = vv_w[ACC_W-1];
                        mul_sh32_next = 1'b0;
                    end
                    PR_TAU2: mul_a_next = MUL_A_W'(tau_reg);
                    PR_TAU3: mul_a_next = MUL_A_W'(tau2_reg);
                    PR_TAU4: mul_a_next = MUL_A_W'(tau3_reg);
                    PR_SV_E: begin
                        mul_a_next    = abs_acc(sv_w);
                        mul_b_next    = el_reg;
                        mul_neg_next  = sv_w[ACC_W-1];
                        mul_sh32_next = 1'b0;
                    end
                    PR_A_TAU2: begin
                        mul_a_next   = abs_acc(ac_w);
                        mul_b_next   = tau2_reg;
                        mul_neg_next = ac_w[ACC_W-1];
                    end
                    PR_J_TAU3: begin
                        mul_a_next   = jc_mag;
                        mul_b_next   = tau3_reg;
                        mul_neg_next = jc_w[ACC_W-1];
                    end
                    PR_Q_TAU4: begin
                        mul_a_next   = abs_acc(qc_w);
                        mul_b_next   = tau4_reg;
                        mul_neg_next = qc_w[ACC_W-1];
                    end
                    PR_2A_TAU: begin
                        mul_a_next   = abs_acc(ac_w) << 1;
                        mul_b_next   = tau_reg;
                        mul_neg_next = ac_w[ACC_W-1];
                    end
                    PR_3J_TAU2: begin
                        mul_a_next   = jc_mag + (jc_mag << 1);
                        mul_b_next   = tau2_reg;
                        mul_neg_next = jc_w[ACC_W-1];
                    end
                    PR_4Q_TAU3: begin
                        mul_a_next   = abs_acc(qc_w) << 2;
                        mul_b_next   = tau3_reg;
                        mul_neg_next = qc_w[ACC_W-1];
                    end
                    default: mul_a_next = '0;
                endcase
            end
            SP_MUL_LO: begin
                plo_next = MUL_PROD_W'(mul_a_reg[MUL_HALF_W-1:0]) * MUL_PROD_W'(mul_b_reg);
            end
            SP_MUL_HI: begin
                phi_next = MUL_PROD_W'(mul_a_reg[MUL_A_W-1:MUL_HALF_W])
                         * MUL_PROD_W'(mul_b_reg);
            end
            SP_MUL_SUM: begin
                prod_next = PROD_W'(plo_reg) + (PROD_W'(phi_reg) << MUL_HALF_W);
            end
            SP_MUL_WB: begin
                case (cmd.prod)
                    PR_SV_T:    p_next       = gp_w - sp_w - mul_res;
                    PR_VV_T:    vt_next      = mul_res;
                    PR_TAU2:    tau2_next    = mul_res[TAU_BITS-1:0];
                    PR_TAU3:    tau3_next    = mul_res[TAU_BITS-1:0];
                    PR_TAU4:    tau4_next    = mul_res[TAU_BITS-1:0];
                    PR_SV_E:    pos_acc_next = sp_w + mul_res;
                    PR_A_TAU2,
                    PR_J_TAU3,
                    PR_Q_TAU4:  pos_acc_next = pos_acc_reg + mul_res;
                    PR_2A_TAU:  d_acc_next   = mul_res;
                    default:    d_acc_next   = d_acc_reg + mul_res;
                endcase
            end
            SP_COEF: begin
                qc_next = sat_coef(q_raw);
                jc_next = sat_coef(j_raw);
                ac_next = sat_coef(a_raw);
            end
            SP_DIV_LOAD: begin
                q_next = '0;
                if (cmd.div_sel == DV_TAU) begin
                    rem_next     = el_reg;
                    lo_next      = '0;
                    div_ovf_next = 1'b0;
                    div_neg_next = 1'b0;
                end else begin
                    rem_next     = dhi[VALUE_W-1:0];
                    lo_next      = {dmag[DIV_PRE_SHIFT-1:0], {FRAC_BITS{1'b0}}};
                    div_ovf_next = (dhi >= ACC_W'(arr_reg));
                    div_neg_next = d_acc_reg[ACC_W-1];
                end
            end
            SP_DIV_RUN: begin
                lo_next = lo_reg << 1;
                if (trial >= {1'b0, arr_reg}) begin
                    rem_next = trial_diff[VALUE_W-1:0];
                    q_next   = {q_reg[DIV_Q_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[VALUE_W-1:0];
                    q_next   = {q_reg[DIV_Q_W-2:0], 1'b0};
                end
            end
            SP_DIV_WB: begin
                if (cmd.div_sel == DV_TAU) begin
                    tau_next = q_reg[TAU_BITS-1:0];
                end else begin
                    cp_next = pos_clamped;
                    cv_next = sat_value(vsum);
                end
            end
            SP_LOAD_OUT: begin
                out_pos_next = cp_reg;
                out_vel_next = cv_reg;
                out_arr_next = (el_reg >= arr_reg);
            end
            default: begin
                op_next = op_reg;
            end
        endcase
    end

    // Motion state clears on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg  <= '0;  sv_reg  <= '0;  gp_reg  <= '0;  gv_reg <= '0;
            cp_reg  <= '0;  cv_reg  <= '0;  arr_reg <= '0;  el_reg <= '0;
            ac_reg  <= '0;  jc_reg  <= '0;  qc_reg  <= '0;
        end else begin
            sp_reg  <= sp_next;  sv_reg  <= sv_next;  gp_reg  <= gp_next;
            gv_reg  <= gv_next;  cp_reg  <= cp_next;  cv_reg  <= cv_next;
            arr_reg <= arr_next; el_reg  <= el_next;
            ac_reg  <= ac_next;  jc_reg  <= jc_next;  qc_reg  <= qc_next;
        end
    end

    // Working and output registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        tpos_reg     <= tpos_next;
        tvel_reg     <= tvel_next;
        ttime_reg    <= ttime_next;
        tstep_reg    <= tstep_next;
        p_reg        <= p_next;
        vt_reg       <= vt_next;
        pos_acc_reg  <= pos_acc_next;
        d_acc_reg    <= d_acc_next;
        tau_reg      <= tau_next;
        tau2_reg     <= tau2_next;
        tau3_reg     <= tau3_next;
        tau4_reg     <= tau4_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        mul_neg_reg  <= mul_neg_next;
        mul_sh32_reg <= mul_sh32_next;
        plo_reg      <= plo_next;
        phi_reg      <= phi_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        lo_reg       <= lo_next;
        div_ovf_reg  <= div_ovf_next;
        div_neg_reg  <= div_neg_next;
        out_pos_reg  <= out_pos_next;
        out_vel_reg  <= out_vel_next;
        out_arr_reg  <= out_arr_next;
    end

    assign m_tdata = {{(OUT_DATA_W-2*VALUE_W-1){1'b0}}, out_arr_reg, out_vel_reg, out_pos_reg};

endmodule
